// File: rtl/core/pawo_pkg.sv
package pawo_pkg;

  localparam int FREQ_W          = 32;
  localparam int FREQ_FRAC_W     = 8;
  localparam int SR_W            = 24;
  localparam int SEL_W           = 2;
  localparam int DUTY_W          = 17;
  localparam int SKEW_W          = 17;
  localparam int SAMPLE_W        = 16;
  localparam int COUNT_W         = 32;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SR_W;

  localparam int DEN_W   = SR_W + FREQ_FRAC_W;
  localparam int WHOLE_W = FREQ_W - FREQ_FRAC_W;
  localparam int FEED_W  = WHOLE_W + PHASE_BITS;
  localparam int STEP_W  = $clog2(FEED_W + 1);
  localparam int TRI_W   = 16;

  localparam int QTR_LEN = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW  = SINE_TABLE_BITS + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WAVEFORM_SEL  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_CYCLE    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIANGLE_SKEW = 2'd3;

  localparam logic [SEL_W-1:0] SEL_SQUARE   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SINE     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_TRIANGLE = 2'd2;

  localparam logic [SR_W-1:0]   SR_RESET   = 24'd48000;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 17'd32768;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic [SAMPLE_W-1:0] sine_rom_t [0:QTR_LEN];

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  divisor;
    logic [DEN_W-1:0]  rem_init;
    logic [FEED_W-1:0] feed;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic [SEL_W-1:0]         sel;
    logic [DUTY_W-1:0]        duty;
    logic signed [SKEW_W-1:0] skew;
  } shape_cfg_t;

  typedef struct packed {
    logic             use_div;
    logic [TRI_W-1:0] num;
    logic [TRI_W-1:0] den;
  } tri_req_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] t;
    longint      s;
    longint      q;
    for (int k = 0; k <= QTR_LEN; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      q = (s + 16384) >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      rom[k] = q[SAMPLE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/pawo_ifs.sv
interface pawo_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [pawo_pkg::FREQ_W-1:0]   frequency;

  modport source (output valid, output cmd, output frequency, input ready);
  modport sink (input valid, input cmd, input frequency, output ready);
endinterface

interface pawo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pawo_pkg::SAMPLE_W-1:0] sample;
  logic [pawo_pkg::COUNT_W-1:0]         period_count;

  modport source (output valid, output sample, output period_count, input ready);
  modport sink (input valid, input sample, input period_count, output ready);
endinterface

interface pawo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pawo_pkg::CFG_ADDR_W-1:0]   addr;
  logic [pawo_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// File: rtl/core/pawo_div.sv
module pawo_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pawo_pkg::div_req_t              req,
  output logic                            busy,
  output logic [pawo_pkg::FEED_W-1:0]     quo
);

  logic [pawo_pkg::DEN_W-1:0]  div_r;
  logic [pawo_pkg::DEN_W-1:0]  rem_r;
  logic [pawo_pkg::DEN_W-1:0]  rem_nxt;
  logic [pawo_pkg::FEED_W-1:0] feed_r;
  logic [pawo_pkg::FEED_W-1:0] quo_r;
  logic [pawo_pkg::STEP_W-1:0] cnt_r;
  logic [pawo_pkg::DEN_W:0]    trial;
  logic [pawo_pkg::DEN_W:0]    diff;
  logic                        fits;

  // one restoring step per cycle
  assign trial   = {rem_r, feed_r[pawo_pkg::FEED_W-1]};
  assign diff    = trial - {1'b0, div_r};
  assign fits    = trial >= {1'b0, div_r};
  assign rem_nxt = fits ? diff[pawo_pkg::DEN_W-1:0] : trial[pawo_pkg::DEN_W-1:0];

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.steps;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r  <= req.divisor;
      rem_r  <= req.rem_init;
      feed_r <= req.feed;
    end else if (busy) begin
      rem_r  <= rem_nxt;
      feed_r <= {feed_r[pawo_pkg::FEED_W-2:0], 1'b0};
      quo_r  <= {quo_r[pawo_pkg::FEED_W-2:0], fits};
    end
  end

endmodule

// File: rtl/core/pawo_shape.sv
module pawo_shape (
  input  logic                                   clk,
  input  pawo_pkg::shape_cfg_t                   cfg,
  input  logic [pawo_pkg::PHASE_BITS-1:0]        phase,
  input  logic [pawo_pkg::TRI_W-1:0]             quo,
  output pawo_pkg::tri_req_t                     tri_req,
  output logic signed [pawo_pkg::SAMPLE_W-1:0]   sample
);

  logic [pawo_pkg::TRI_W-1:0]             p16;
  logic [pawo_pkg::SINE_TABLE_BITS+1:0]   top;
  logic [1:0]                             quad;
  logic [pawo_pkg::SINE_TABLE_BITS-1:0]   idx;
  logic [pawo_pkg::ROM_AW-1:0]            rom_addr;
  logic [pawo_pkg::SAMPLE_W-1:0]          rom_q_r;
  logic signed [pawo_pkg::SAMPLE_W-1:0]   sine_v;
  logic                                   square_hi;
  logic signed [17:0]                     d_s;
  logic [pawo_pkg::TRI_W-1:0]             d16;
  logic                                   d_low;
  logic                                   d_high;
  logic                                   rising;
  logic signed [17:0]                     tri_v;
  logic signed [pawo_pkg::SAMPLE_W-1:0]   tri_sat;

  assign p16 = phase[pawo_pkg::PHASE_BITS-1 -: pawo_pkg::TRI_W];

  // square
  assign square_hi = {1'b0, p16} < cfg.duty;

  // sine, quarter-wave rom with mirror and sign
  assign top  = phase[pawo_pkg::PHASE_BITS-1 -: pawo_pkg::SINE_TABLE_BITS + 2];
  assign quad = top[pawo_pkg::SINE_TABLE_BITS+1:pawo_pkg::SINE_TABLE_BITS];
  assign idx  = top[pawo_pkg::SINE_TABLE_BITS-1:0];
  assign rom_addr = quad[0] ? (pawo_pkg::ROM_AW'(pawo_pkg::QTR_LEN) - {1'b0, idx})
                            : {1'b0, idx};

  always_ff @(posedge clk) begin
    rom_q_r <= pawo_pkg::SINE_ROM[rom_addr];
  end

  assign sine_v = quad[1] ? -$signed(rom_q_r) : $signed(rom_q_r);

  // skewed triangle
  assign d_s    = 18'($signed(cfg.skew)) + 18'sd32768;
  assign d16    = d_s[pawo_pkg::TRI_W-1:0];
  assign d_low  = d_s[17] || (d_s == 18'sd0);
  assign d_high = !d_s[17] && d_s[16];
  assign rising = p16 < d16;

  assign tri_req.use_div = !d_low && !d_high;
  assign tri_req.num     = rising ? p16 : p16 - d16;
  assign tri_req.den     = rising ? d16 : pawo_pkg::TRI_W'(17'h10000 - {1'b0, d16});

  always_comb begin
    priority if (d_low) begin
      tri_v = 18'sd32768 - $signed({2'b00, p16});
    end else if (d_high) begin
      tri_v = $signed({2'b00, p16}) - 18'sd32768;
    end else if (rising) begin
      tri_v = $signed({2'b00, quo}) - 18'sd32768;
    end else begin
      tri_v = 18'sd32768 - $signed({2'b00, quo});
    end
  end

  assign tri_sat = (tri_v > 18'sd32767) ? pawo_pkg::SAMPLE_MAX
                                        : tri_v[pawo_pkg::SAMPLE_W-1:0];

  always_comb begin
    unique case (cfg.sel)
      pawo_pkg::SEL_SQUARE:   sample = square_hi ? pawo_pkg::SAMPLE_MAX : pawo_pkg::SAMPLE_MIN;
      pawo_pkg::SEL_SINE:     sample = sine_v;
      pawo_pkg::SEL_TRIANGLE: sample = tri_sat;
      default:                sample = '0;
    endcase
  end

endmodule

// File: rtl/core/phase_accumulator_waveform_oscillator_unit.sv
// tick: S_INC, S_ADD, S_PER, S_WAVE, S_SHAPE from input transaction to output valid,
//   S_TRI too for a skewed triangle between its end ramps (bit-serial divider, one
//   quotient bit per cycle); restart: S_WAVE, S_SHAPE, S_TRI too for that triangle
// inputs: one transaction at a time; the next input is taken, in S_IDLE, while a
//   finished result still waits in the output register
// reset: synchronous active low, config to defaults, phase and period count zero
module phase_accumulator_waveform_oscillator_unit (
  input logic        clk,
  input logic        rst_n,
  pawo_in_if.sink    in_chan,
  pawo_out_if.source out_chan,
  pawo_cfg_if.sink   cfg_chan
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INC   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PER   = 3'd3;
  localparam logic [2:0] S_WAVE  = 3'd4;
  localparam logic [2:0] S_TRI   = 3'd5;
  localparam logic [2:0] S_SHAPE = 3'd6;

  logic [2:0]                               state_r;
  logic [2:0]                               state_nxt;
  logic [pawo_pkg::PHASE_BITS-1:0]          phase_r;
  logic [pawo_pkg::COUNT_W-1:0]             periods_r;
  logic                                     carry_r;
  logic                                     out_valid_r;
  logic signed [pawo_pkg::SAMPLE_W-1:0]     out_sample_r;
  logic [pawo_pkg::COUNT_W-1:0]             out_count_r;

  logic [pawo_pkg::SR_W-1:0]                sr_r;
  logic [pawo_pkg::SEL_W-1:0]               sel_r;
  logic [pawo_pkg::DUTY_W-1:0]              duty_r;
  logic signed [pawo_pkg::SKEW_W-1:0]       skew_r;

  logic                                     in_fire;
  logic                                     cfg_fire;
  logic                                     out_load;
  logic [pawo_pkg::SR_W-1:0]                sr_eff;
  logic [pawo_pkg::PHASE_BITS:0]            sum;
  logic [pawo_pkg::WHOLE_W-1:0]             whole;
  logic [pawo_pkg::PHASE_BITS-1:0]          frac;

  pawo_pkg::div_req_t                       div_req;
  logic                                     div_busy;
  logic [pawo_pkg::FEED_W-1:0]              div_quo;
  pawo_pkg::shape_cfg_t                     shape_cfg;
  pawo_pkg::tri_req_t                       tri_req;
  logic signed [pawo_pkg::SAMPLE_W-1:0]     sample;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample       = out_sample_r;
  assign out_chan.period_count = out_count_r;

  assign sr_eff = (sr_r == '0) ? pawo_pkg::SR_W'(1) : sr_r;
  assign whole  = div_quo[pawo_pkg::FEED_W-1:pawo_pkg::PHASE_BITS];
  assign frac   = div_quo[pawo_pkg::PHASE_BITS-1:0];
  assign sum    = {1'b0, phase_r} + {1'b0, frac};

  assign out_load = (state_r == S_SHAPE) && (!out_valid_r || out_chan.ready);

  // divider requests: phase increment on a tick, slope on the triangle
  always_comb begin
    div_req = '0;
    if (in_fire && !in_chan.cmd) begin
      div_req.start    = 1'b1;
      div_req.divisor  = {sr_eff, pawo_pkg::FREQ_FRAC_W'(0)};
      div_req.rem_init = pawo_pkg::DEN_W'(
                           in_chan.frequency[pawo_pkg::FREQ_W-1 -: pawo_pkg::FREQ_FRAC_W]);
      div_req.feed     = {in_chan.frequency[pawo_pkg::WHOLE_W-1:0],
                          pawo_pkg::PHASE_BITS'(0)};
      div_req.steps    = pawo_pkg::STEP_W'(pawo_pkg::FEED_W);
    end else if (state_r == S_WAVE && sel_r == pawo_pkg::SEL_TRIANGLE && tri_req.use_div) begin
      div_req.start    = 1'b1;
      div_req.divisor  = pawo_pkg::DEN_W'(tri_req.den);
      div_req.rem_init = pawo_pkg::DEN_W'(tri_req.num);
      div_req.feed     = '0;
      div_req.steps    = pawo_pkg::STEP_W'(pawo_pkg::TRI_W);
    end
  end

  pawo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign shape_cfg.sel  = sel_r;
  assign shape_cfg.duty = duty_r;
  assign shape_cfg.skew = skew_r;

  pawo_shape u_shape (
    .clk     (clk),
    .cfg     (shape_cfg),
    .phase   (phase_r),
    .quo     (div_quo[pawo_pkg::TRI_W-1:0]),
    .tri_req (tri_req),
    .sample  (sample)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_chan.cmd ? S_WAVE : S_INC;
        end
      end
      S_INC: begin
        if (!div_busy) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:  state_nxt = S_PER;
      S_PER:  state_nxt = S_WAVE;
      S_WAVE: begin
        if (div_req.start) begin
          state_nxt = S_TRI;
        end else begin
          state_nxt = S_SHAPE;
        end
      end
      S_TRI: begin
        if (!div_busy) begin
          state_nxt = S_SHAPE;
        end
      end
      S_SHAPE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      periods_r   <= '0;
      out_valid_r <= 1'b0;
      sr_r        <= pawo_pkg::SR_RESET;
      sel_r       <= pawo_pkg::SEL_SQUARE;
      duty_r      <= pawo_pkg::DUTY_RESET;
      skew_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_chan.cmd) begin
        phase_r   <= '0;
        periods_r <= '0;
      end else if (state_r == S_ADD) begin
        phase_r <= sum[pawo_pkg::PHASE_BITS-1:0];
      end else if (state_r == S_PER) begin
        periods_r <= periods_r + pawo_pkg::COUNT_W'(whole) + pawo_pkg::COUNT_W'(carry_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_chan.addr)
          pawo_pkg::REG_SAMPLE_RATE:   sr_r   <= cfg_chan.data[pawo_pkg::SR_W-1:0];
          pawo_pkg::REG_WAVEFORM_SEL:  sel_r  <= cfg_chan.data[pawo_pkg::SEL_W-1:0];
          pawo_pkg::REG_DUTY_CYCLE:    duty_r <= cfg_chan.data[pawo_pkg::DUTY_W-1:0];
          pawo_pkg::REG_TRIANGLE_SKEW: skew_r <= $signed(cfg_chan.data[pawo_pkg::SKEW_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ADD) begin
      carry_r <= sum[pawo_pkg::PHASE_BITS];
    end
    if (out_load) begin
      out_sample_r <= sample;
      out_count_r  <= periods_r;
    end
  end

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_busy)
    else $error("divider busy while idle");

  a_add_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> !div_busy && $past(state_r) == S_INC)
    else $error("phase add before increment division finished");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.cmd |=> phase_r == '0 && periods_r == '0 && state_r == S_WAVE)
    else $error("restart did not clear phase and period count");

  a_out_from_shape: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_SHAPE)
    else $error("result raised outside shaping step");

endmodule
